// File: src/dtf_pkg.sv
package dtf_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int CAT_W  = 8;
   localparam int BOX_W  = 13;
   localparam int CONF_W = 16;
   localparam int CNTR_W = 8;
   localparam int TOL_W  = 16;
   localparam int SF_W   = 9;
   localparam int FS_W   = 14;
   localparam int THR_W  = TOL_W + FS_W;
   localparam int DATA_W = 80;
   localparam int USER_W = 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_TOLERANCE = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SMOOTHING = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_VISIBLE   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_HIDDEN    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_W   = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_H   = 3'd5;

   localparam logic [SF_W-1:0] SF_ONE = 9'd256;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_BLEND,
      ST_AGE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [CAT_W-1:0]  cat;
      logic [BOX_W-1:0]  x;
      logic [BOX_W-1:0]  y;
      logic [BOX_W-1:0]  w;
      logic [BOX_W-1:0]  h;
      logic [CONF_W-1:0] conf;
      logic [CNTR_W-1:0] vis;
      logic [CNTR_W-1:0] hid;
      logic              matched;
   } entry_type;

   typedef struct packed {
      logic load;
      logic clr_idx;
      logic idx_inc;
      logic append;
      logic clr_field;
      logic blend;
      logic age_step;
      logic age_fin;
      logic emit_load;
      logic emit_empty;
   } cmd_type;

   typedef struct packed {
      logic at_end;
      logic hit;
      logic det_last;
      logic field_last;
      logic out_free;
      logic emit_zero;
      logic ent_hidden;
      logic emit_last;
   } sts_type;

endpackage

// File: src/dtf_ctrl.sv
module dtf_ctrl
   import dtf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_fire,
   input  sts_type sts,
   output logic    req_ready,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (sts.at_end) state_in = sts.det_last ? ST_AGE : ST_IDLE;
            else if (sts.hit) state_in = ST_BLEND;
         end
         ST_BLEND: begin
            if (sts.field_last) state_in = sts.det_last ? ST_AGE : ST_IDLE;
         end
         ST_AGE: begin
            if (sts.at_end) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.emit_zero) begin
               if (sts.out_free) state_in = ST_IDLE;
            end else if (!sts.ent_hidden && sts.out_free && sts.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load    = req_fire;
            cmd.clr_idx = req_fire;
         end
         ST_SEARCH: begin
            if (sts.at_end) begin
               cmd.append  = 1'b1;
               cmd.clr_idx = 1'b1;
            end else if (sts.hit) begin
               cmd.clr_field = 1'b1;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_BLEND: begin
            cmd.blend   = 1'b1;
            cmd.clr_idx = sts.field_last;
         end
         ST_AGE: begin
            if (sts.at_end) cmd.age_fin = 1'b1;
            else cmd.age_step = 1'b1;
         end
         ST_EMIT: begin
            if (sts.emit_zero) begin
               cmd.emit_empty = sts.out_free;
            end else if (sts.ent_hidden) begin
               cmd.idx_inc = 1'b1;
            end else if (sts.out_free) begin
               cmd.emit_load = 1'b1;
               cmd.idx_inc   = 1'b1;
            end
         end
         default: ;
      endcase
   end

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.append, cmd.blend, cmd.age_step, cmd.emit_load, cmd.emit_empty}))
      else $error("conflicting table commands");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_SEARCH)
      else $error("accepted beat did not start a search");
   a_emit_ends: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_empty |=> state_ff == ST_IDLE)
      else $error("empty result did not close the frame");

endmodule

// File: src/dtf_dp.sv
module dtf_dp
   import dtf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [DATA_W-1:0]     req_tdata,
   input  logic                  req_tlast,
   input  logic                  rsp_tready,
   input  cmd_type               cmd,
   output sts_type               sts,
   output logic                  rsp_tvalid,
   output logic [DATA_W-1:0]     rsp_tdata,
   output logic [USER_W-1:0]     rsp_tuser,
   output logic                  rsp_tlast
);

   // configuration
   logic [TOL_W-1:0]  tol_ff;
   logic [SF_W-1:0]   sf_ff;
   logic [CNTR_W-1:0] visf_ff, hidf_ff;
   logic [FS_W-1:0]   fw_ff, fh_ff;
   logic [THR_W-1:0]  thr_w_ff, thr_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff  <= TOL_W'(3277);
         sf_ff   <= SF_W'(51);
         visf_ff <= CNTR_W'(5);
         hidf_ff <= CNTR_W'(2);
         fw_ff   <= FS_W'(1920);
         fh_ff   <= FS_W'(1080);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_TOLERANCE: tol_ff  <= csr_wdata[TOL_W-1:0];
            CSR_SMOOTHING: sf_ff   <= csr_wdata[SF_W-1:0];
            CSR_VISIBLE:   visf_ff <= csr_wdata[CNTR_W-1:0];
            CSR_HIDDEN:    hidf_ff <= csr_wdata[CNTR_W-1:0];
            CSR_FRAME_W:   fw_ff   <= csr_wdata[FS_W-1:0];
            CSR_FRAME_H:   fh_ff   <= csr_wdata[FS_W-1:0];
            default: ;
         endcase
      end
   end

   // match thresholds, registered products
   always_ff @(posedge clock) begin
      thr_w_ff <= THR_W'(tol_ff) * THR_W'(fw_ff);
      thr_h_ff <= THR_W'(tol_ff) * THR_W'(fh_ff);
   end

   // detection latch
   entry_type det_ff;
   logic      last_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         det_ff.cat  <= req_tdata[7:0];
         det_ff.x    <= req_tdata[20:8];
         det_ff.y    <= req_tdata[33:21];
         det_ff.w    <= req_tdata[46:34];
         det_ff.h    <= req_tdata[59:47];
         det_ff.conf <= req_tdata[75:60];
         det_ff.vis  <= visf_ff;
         det_ff.hid  <= hidf_ff;
         det_ff.matched <= 1'b1;
         last_ff     <= req_tlast;
      end
   end

   // table and counters
   entry_type        tbl_ff [TABLE_DEPTH];
   entry_type        tbl_in [TABLE_DEPTH];
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] nnew_ff, nnew_in;
   logic [CNT_W-1:0] etot_ff, etot_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [1:0]       fld_ff, fld_in;
   logic             drop_ff, drop_in;

   entry_type ent;
   assign ent = tbl_ff[idx_ff[IDX_W-1:0]];

   function automatic logic near(input logic [BOX_W-1:0] a, input logic [BOX_W-1:0] b,
                                 input logic [THR_W-1:0] thr);
      logic [BOX_W-1:0] d;
      begin
         d = (a > b) ? a - b : b - a;
         near = THR_W'({d, 16'd0}) < thr;
      end
   endfunction

   logic hit;
   assign hit = ent.cat == det_ff.cat && near(det_ff.x, ent.x, thr_w_ff) &&
                near(det_ff.y, ent.y, thr_h_ff) && near(det_ff.w, ent.w, thr_w_ff) &&
                near(det_ff.h, ent.h, thr_h_ff);

   // blend one field: old + floor(s * (det - old) / 256)
   logic [SF_W-1:0]         s_clip;
   logic [BOX_W-1:0]        b_det, b_old;
   logic signed [BOX_W:0]   b_diff;
   logic signed [BOX_W+SF_W+1:0] b_prod;
   logic signed [BOX_W+SF_W+1:0] b_sum;
   logic [BOX_W-1:0]        b_res;

   always_comb begin
      s_clip = (sf_ff > SF_ONE) ? SF_ONE : sf_ff;
      case (fld_ff)
         2'd0:    begin b_det = det_ff.x; b_old = ent.x; end
         2'd1:    begin b_det = det_ff.y; b_old = ent.y; end
         2'd2:    begin b_det = det_ff.w; b_old = ent.w; end
         default: begin b_det = det_ff.h; b_old = ent.h; end
      endcase
      b_diff = $signed({1'b0, b_det}) - $signed({1'b0, b_old});
      b_prod = $signed({1'b0, s_clip}) * b_diff;
      b_sum  = (b_prod >>> 8) + $signed({{(SF_W+2){1'b0}}, b_old});
      b_res  = b_sum[BOX_W-1:0];
   end

   // ageing decision
   logic      keep;
   entry_type aged;
   always_comb begin
      aged = ent;
      aged.matched = 1'b0;
      keep = ent.matched || (ent.hid == '0 && ent.vis > CNTR_W'(1));
      if (!ent.matched) aged.vis = ent.vis - CNTR_W'(1);
   end

   always_comb begin
      tbl_in  = tbl_ff;
      cnt_in  = cnt_ff;
      idx_in  = idx_ff;
      nnew_in = nnew_ff;
      etot_in = etot_ff;
      k_in    = k_ff;
      fld_in  = fld_ff;
      drop_in = drop_ff;
      if (cmd.clr_idx) begin
         idx_in  = '0;
         nnew_in = '0;
         etot_in = '0;
         k_in    = '0;
      end
      if (cmd.idx_inc) idx_in = idx_ff + CNT_W'(1);
      if (cmd.append) begin
         if (cnt_ff < CNT_W'(TABLE_DEPTH)) begin
            tbl_in[cnt_ff[IDX_W-1:0]] = det_ff;
            cnt_in = cnt_ff + CNT_W'(1);
         end else begin
            drop_in = 1'b1;
         end
      end
      if (cmd.clr_field) fld_in = '0;
      if (cmd.blend) begin
         fld_in = fld_ff + 2'd1;
         case (fld_ff)
            2'd0:    tbl_in[idx_ff[IDX_W-1:0]].x = b_res;
            2'd1:    tbl_in[idx_ff[IDX_W-1:0]].y = b_res;
            2'd2:    tbl_in[idx_ff[IDX_W-1:0]].w = b_res;
            default: begin
               tbl_in[idx_ff[IDX_W-1:0]].h       = b_res;
               tbl_in[idx_ff[IDX_W-1:0]].conf    = det_ff.conf;
               tbl_in[idx_ff[IDX_W-1:0]].vis     = visf_ff;
               tbl_in[idx_ff[IDX_W-1:0]].hid     = (ent.hid != '0) ? ent.hid - CNTR_W'(1) : '0;
               tbl_in[idx_ff[IDX_W-1:0]].matched = 1'b1;
            end
         endcase
      end
      if (cmd.age_step) begin
         idx_in = idx_ff + CNT_W'(1);
         if (keep) begin
            tbl_in[nnew_ff[IDX_W-1:0]] = aged;
            nnew_in = nnew_ff + CNT_W'(1);
            if (ent.hid == '0) etot_in = etot_ff + CNT_W'(1);
         end
      end
      if (cmd.age_fin) begin
         cnt_in = nnew_ff;
         idx_in = '0;
      end
      if (cmd.emit_load) k_in = k_ff + CNT_W'(1);
      if (cmd.emit_empty || (cmd.emit_load && sts.emit_last)) drop_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      tbl_ff  <= tbl_in;
      idx_ff  <= idx_in;
      nnew_ff <= nnew_in;
      etot_ff <= etot_in;
      k_ff    <= k_in;
      fld_ff  <= fld_in;
      if (reset) begin
         cnt_ff  <= '0;
         drop_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         drop_ff <= drop_in;
      end
   end

   // output register
   logic              valid_ff, valid_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic [USER_W-1:0] user_ff, user_in;
   logic              olast_ff, olast_in;

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      data_in  = data_ff;
      user_in  = user_ff;
      olast_in = olast_ff;
      if (cmd.emit_load) begin
         valid_in = 1'b1;
         data_in  = {4'd0, ent.conf, ent.h, ent.w, ent.y, ent.x, ent.cat};
         user_in  = {drop_ff, 1'b1};
         olast_in = sts.emit_last;
      end else if (cmd.emit_empty) begin
         valid_in = 1'b1;
         data_in  = '0;
         user_in  = {drop_ff, 1'b0};
         olast_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      user_ff  <= user_in;
      olast_ff <= olast_in;
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = olast_ff;

   always_comb begin
      sts.at_end     = idx_ff == cnt_ff;
      sts.hit        = hit;
      sts.det_last   = last_ff;
      sts.field_last = fld_ff == 2'd3;
      sts.out_free   = !valid_ff || rsp_tready;
      sts.emit_zero  = etot_ff == '0;
      sts.ent_hidden = ent.hid != '0;
      sts.emit_last  = k_ff == etot_ff - CNT_W'(1);
   end

   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(TABLE_DEPTH))
      else $error("table count beyond depth");
   a_compact: assert property (@(posedge clock) disable iff (reset)
      cmd.age_step |-> nnew_ff <= idx_ff)
      else $error("compaction write overtook read");
   a_emit_cnt: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_load |-> k_ff < etot_ff)
      else $error("more results than counted");

endmodule

// File: src/detection_temporal_filter.sv
// A detection is accepted, then compared with the table entries one by one; a miss
// appends it if the table has room, a match smooths the four box fields of that entry
// one by one. A frame-end beat then ages the table and emits one result per reported
// entry (or one empty result), each held while the output register is full. Only one
// detection is processed at a time; a new beat is accepted only while idle.
// Reset (sync, active high) empties the table, clears drop, loads defaults.
module detection_temporal_filter
   import dtf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // category, box_x, box_y, box_width, box_height, confidence, zero pad
   input  logic [DATA_W-1:0]     req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // category_res, box_x_res, box_y_res, box_width_res, box_height_res,
   // confidence_res, zero pad
   output logic [DATA_W-1:0]     rsp_tdata,
   // present, table_full_drop
   output logic [USER_W-1:0]     rsp_tuser,
   output logic                  rsp_tlast
);

   cmd_type cmd;
   sts_type sts;
   logic    req_fire;

   // a beat enters only while the controller sits idle
   assign req_fire = req_tvalid && req_tready;

   dtf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .sts       (sts),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   // table, config registers, blend unit and output register
   dtf_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
